// ===== src/assert_macros.svh =====
// Assertion macros shared by the slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jsa_pkg.sv =====
// Shared constants, types and state encoding for the join slot allocator.
package jsa_pkg;

    // Default number of slots in the registry.
    localparam int SLOT_COUNT_DEF = 8;

    // Fixed field widths.
    localparam int ID_W   = 16;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 8;

    // Scan sequencer states.
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // One finished result, handed from the sequencer to the output register.
    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot_number;
        logic              newly_assigned;
        logic [MASK_W-1:0] occupancy_mask;
    } t_result;

endpackage

// ===== src/jsa_id_table.sv =====
// Slot table: one occupancy bit and one device identifier per slot.
module jsa_id_table #(
    parameter int  SLOT_COUNT = jsa_pkg::SLOT_COUNT_DEF,
    localparam int PTR_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [PTR_W-1:0]        i_addr,
    input  logic [PTR_W-1:0]        i_rd_addr,
    input  logic                    i_wr_en,
    input  logic [jsa_pkg::ID_W-1:0] i_wr_id,
    output logic                    o_rd_valid,
    output logic [jsa_pkg::ID_W-1:0] o_rd_id,
    output logic [SLOT_COUNT-1:0]   o_valid_vec
);
    import jsa_pkg::*;

    logic [SLOT_COUNT-1:0] r_valid;
    logic [ID_W-1:0]       r_id [SLOT_COUNT];
    logic [ID_W-1:0]       r_rd_id;

    // Occupancy bits are cleared by reset and set when a slot is claimed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // Identifiers need no reset; they are only read behind a set occupancy bit.
    // The read is registered, so the address given is that of the next scan step.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id[i_addr] <= i_wr_id;
        end
        r_rd_id <= r_id[i_rd_addr];
    end

    // Occupancy of the entry under the scan address and the registered identifier.
    assign o_rd_valid  = r_valid[i_addr];
    assign o_rd_id     = r_rd_id;
    assign o_valid_vec = r_valid;

endmodule

// ===== src/jsa_scan_ctrl.sv =====
// Scan sequencer: walks the slot table one entry a cycle with a shared comparator.
module jsa_scan_ctrl #(
    parameter int  SLOT_COUNT = jsa_pkg::SLOT_COUNT_DEF,
    localparam int PTR_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [jsa_pkg::ID_W-1:0] i_device_id,
    input  logic                     i_out_free,
    input  logic                     i_rd_valid,
    input  logic [jsa_pkg::ID_W-1:0] i_rd_id,
    input  logic [SLOT_COUNT-1:0]    i_valid_vec,
    output logic                     o_idle,
    output logic [PTR_W-1:0]         o_addr,
    output logic [PTR_W-1:0]         o_rd_addr,
    output logic                     o_wr_en,
    output logic [jsa_pkg::ID_W-1:0] o_wr_id,
    output logic                     o_load,
    output jsa_pkg::t_result         o_result
);
    import jsa_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOT_COUNT - 1);

    t_state          r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [ID_W-1:0]  r_req_id, n_req_id;

    logic w_hit;
    logic w_free;
    logic w_finish;

    // Compare the entry under the pointer with the requested identifier.
    // Slots are claimed lowest first and never released, so the first free
    // entry marks the end of the occupied ones.
    assign w_hit    = i_rd_valid && (i_rd_id == r_req_id);
    assign w_free   = !i_rd_valid;
    assign w_finish = w_hit || w_free || (r_ptr == PTR_LAST);

    // Result of the entry under the pointer, valid when the scan finishes.
    always_comb begin
        o_result.granted        = w_hit || w_free;
        o_result.slot_number    = (w_hit || w_free) ? (SLOT_W'(r_ptr) + SLOT_W'(1))
                                                    : '0;
        o_result.newly_assigned = w_free;
        o_result.occupancy_mask = MASK_W'(i_valid_vec)
                                | (w_free ? (MASK_W'(1) << r_ptr) : '0);
    end

    // State, pointer and request registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_id <= n_req_id;
    end

    // Next state and outputs.
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_req_id = r_req_id;
        o_idle   = 1'b0;
        o_wr_en  = 1'b0;
        o_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_req_id = i_device_id;
                    n_ptr    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_finish) begin
                    // Hold on this entry until the output register has room.
                    if (i_out_free) begin
                        o_load  = 1'b1;
                        o_wr_en = w_free;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The identifier read is registered, so the table is addressed with the
    // next pointer value and its data lines up with the pointer.
    assign o_addr    = r_ptr;
    assign o_rd_addr = n_ptr;
    assign o_wr_id   = r_req_id;

endmodule

// ===== src/join_slot_allocator.sv =====
// Top level of the join slot allocator: handshakes, output register and checks.
//
// Each join request is accepted while the sequencer is idle, and the sequencer
// then steps through the slot table entries, stopping at the first entry that
// matches the identifier or is free, or at the last entry. The single table read
// port and the one identifier comparator are stepped across the entries, and no
// new request is accepted while a scan is under way. A
// finished result sits in an output register, so a new request can be accepted
// while the previous result still waits to be taken; the scan stalls on its
// final entry only if that register is still full when it finishes. There is
// no clearing pass after reset: the occupancy bits clear at once.
module join_slot_allocator #(
    parameter int SLOT_COUNT = jsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [jsa_pkg::ID_W-1:0]   i_device_id,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_granted,
    output logic [jsa_pkg::SLOT_W-1:0] o_slot_number,
    output logic                       o_newly_assigned,
    output logic [jsa_pkg::MASK_W-1:0] o_occupancy_mask
);
    import jsa_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                  w_idle;
    logic                  w_start;
    logic                  w_out_free;
    logic [PTR_W-1:0]      w_addr;
    logic [PTR_W-1:0]      w_rd_addr;
    logic                  w_wr_en;
    logic [ID_W-1:0]       w_wr_id;
    logic                  w_rd_valid;
    logic [ID_W-1:0]       w_rd_id;
    logic [SLOT_COUNT-1:0] w_valid_vec;
    logic                  w_load;
    t_result               w_result;

    logic                  r_out_valid;
    t_result               r_out;

    // Input transfer and room in the output register.
    assign o_ready    = w_idle;
    assign w_start    = i_valid && w_idle;
    assign w_out_free = !r_out_valid || i_ready;

    jsa_id_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_addr      (w_addr),
        .i_rd_addr   (w_rd_addr),
        .i_wr_en     (w_wr_en),
        .i_wr_id     (w_wr_id),
        .o_rd_valid  (w_rd_valid),
        .o_rd_id     (w_rd_id),
        .o_valid_vec (w_valid_vec)
    );

    jsa_scan_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_device_id (i_device_id),
        .i_out_free  (w_out_free),
        .i_rd_valid  (w_rd_valid),
        .i_rd_id     (w_rd_id),
        .i_valid_vec (w_valid_vec),
        .o_idle      (w_idle),
        .o_addr      (w_addr),
        .o_rd_addr   (w_rd_addr),
        .o_wr_en     (w_wr_en),
        .o_wr_id     (w_wr_id),
        .o_load      (w_load),
        .o_result    (w_result)
    );

    // Output register: loaded when a scan finishes, emptied by an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_granted        = r_out.granted;
    assign o_slot_number    = r_out.slot_number;
    assign o_newly_assigned = r_out.newly_assigned;
    assign o_occupancy_mask = r_out.occupancy_mask;

    // Occupied slots always form a run starting at the lowest slot.
    `JSA_ASSERT_IMP(a_valid_prefix, i_clk, i_rst_n, 1'b1, (w_valid_vec & (w_valid_vec + SLOT_COUNT'(1))) == '0, "occupied slots are not a contiguous run from slot 1")

    // A slot, once occupied, stays occupied until reset.
    `JSA_ASSERT_NXT(a_valid_keep, i_clk, i_rst_n, $past(i_rst_n), (w_valid_vec & $past(w_valid_vec)) == $past(w_valid_vec), "an occupied slot was released")

    // The table is written only when a result is loaded into the output register.
    `JSA_ASSERT_IMP(a_write_with_load, i_clk, i_rst_n, w_wr_en, w_load && w_result.newly_assigned, "slot claimed without a matching result")

endmodule
